### rtl/sme_pkg.sv
// ----------------------------------------------------------------------------
// sme_pkg
// Shared types and constants for the stable matching engine.
// ----------------------------------------------------------------------------
package sme_pkg;

   localparam int PERSON_W           = 4;
   localparam int MAX_PEOPLE         = 16;
   localparam int DEFAULT_NUM_PEOPLE = 16;

   localparam logic [1:0] OP_LOAD_PROP = 2'd0;
   localparam logic [1:0] OP_LOAD_ACC  = 2'd1;
   localparam logic [1:0] OP_RUN       = 2'd2;

   typedef struct packed {
      logic [1:0]          op;
      logic [PERSON_W-1:0] person;
      logic [PERSON_W-1:0] rank_pos;
      logic [PERSON_W-1:0] partner;
   } req_type;

   typedef struct packed {
      logic [PERSON_W-1:0] proposer;
      logic [PERSON_W-1:0] matched_acceptor;
      logic                last;
   } rsp_type;

   // read request into the preference tables
   typedef struct packed {
      logic                en;
      logic                rank;
      logic [PERSON_W-1:0] row;
      logic [PERSON_W-1:0] col;
   } tbl_rd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIND,
      ST_NEXT,
      ST_PREF,
      ST_ACC,
      ST_RANK_NEW,
      ST_RANK_OLD,
      ST_OUT_RD,
      ST_OUT_WR
   } state_type;

endpackage

### rtl/stable_matching_engine.sv
// ----------------------------------------------------------------------------
// stable_matching_engine
// Proposer-optimal stable matching over two loaded preference tables.
// ----------------------------------------------------------------------------
// Requests arrive on req_valid/req_ready with a req_data struct. A load
// request writes one preference entry; loads may be issued back to back. A
// run request clears the matching state and then iterates proposals. Each
// proposal picks the lowest free proposer and reads her next position, then
// her choice from the preference table. An acceptor index out of range ends
// the proposal there; a free acceptor is engaged; for a taken one the new
// and the old proposer's ranks are read in turn and compared. A final find
// step sees no free proposer. With full permutations a run makes at most
// PEOPLE*PEOPLE proposals. The run then emits PEOPLE responses on
// rsp_valid/rsp_ready, proposer ascending, last set on the final one. A
// stalled response holds in the output register and the sequencer waits.
// req_ready is high whenever no run is in progress. Synchronous reset
// returns the sequencer to idle and empties the output register; the
// preference tables keep their contents and need no clearing pass.
// ----------------------------------------------------------------------------
module stable_matching_engine #(
   parameter int NUM_PEOPLE = sme_pkg::DEFAULT_NUM_PEOPLE
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sme_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sme_pkg::rsp_type rsp_data
);

   localparam int PEOPLE = (NUM_PEOPLE < sme_pkg::MAX_PEOPLE) ? NUM_PEOPLE
                                                              : sme_pkg::MAX_PEOPLE;
   localparam int IW = $clog2(PEOPLE);
   localparam int NW = $clog2(PEOPLE + 1);
   localparam int PW = sme_pkg::PERSON_W;

   sme_pkg::state_type state_ff, state_in;

   logic [IW-1:0]     cur_p_ff, cur_p_in;
   logic [IW-1:0]     acc_ff, acc_in;
   logic [IW-1:0]     old_ff, old_in;
   logic [IW-1:0]     cnt_ff, cnt_in;
   logic [PW-1:0]     rnew_ff, rnew_in;
   logic [PEOPLE-1:0] pfree_ff, pfree_in;
   logic [PEOPLE-1:0] pexh_ff, pexh_in;
   logic [PEOPLE-1:0] ncv_ff, ncv_in;
   logic [PEOPLE-1:0] accv_ff, accv_in;
   logic              rsp_valid_ff, rsp_valid_in;
   sme_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   // matching state memories
   logic [NW-1:0] nc_mem  [PEOPLE];
   logic [IW-1:0] acc_mem [PEOPLE];
   logic [IW-1:0] pp_mem  [PEOPLE];
   logic [NW-1:0] nc_q_ff;
   logic [IW-1:0] acc_q_ff;
   logic [IW-1:0] pp_q_ff;

   logic          nc_re, nc_we;
   logic [IW-1:0] nc_ra, nc_wa;
   logic [NW-1:0] nc_wd;
   logic          acc_re, acc_we;
   logic [IW-1:0] acc_ra, acc_wa, acc_wd;
   logic          pp_re, pp_we;
   logic [IW-1:0] pp_ra, pp_wa, pp_wd;

   logic                req_fire;
   sme_pkg::tbl_rd_type tbl_rd;
   logic [PW-1:0]       tbl_q;

   logic [PEOPLE-1:0] cand;
   logic              found;
   logic [IW-1:0]     found_p;
   logic [NW-1:0]     nc_cur;
   logic [NW-1:0]     nc_next;

   assign req_ready = (state_ff == sme_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   sme_tables #(
      .PEOPLE (PEOPLE)
   ) u_tables (
      .clock    (clock),
      .load_en  (req_fire),
      .load_req (req_data),
      .rd       (tbl_rd),
      .rd_data  (tbl_q)
   );

   // lowest free proposer with an untried position
   always_comb begin
      cand    = pfree_ff & ~pexh_ff;
      found   = |cand;
      found_p = '0;
      for (int i = PEOPLE - 1; i >= 0; i--) begin
         if (cand[i]) begin
            found_p = IW'(i);
         end
      end
   end

   always_comb begin
      nc_cur  = ncv_ff[cur_p_ff] ? nc_q_ff : '0;
      nc_next = nc_cur + NW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sme_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_p_ff    <= cur_p_in;
      acc_ff      <= acc_in;
      old_ff      <= old_in;
      cnt_ff      <= cnt_in;
      rnew_ff     <= rnew_in;
      pfree_ff    <= pfree_in;
      pexh_ff     <= pexh_in;
      ncv_ff      <= ncv_in;
      accv_ff     <= accv_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (nc_we) begin
         nc_mem[nc_wa] <= nc_wd;
      end
      if (nc_re) begin
         nc_q_ff <= nc_mem[nc_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[acc_wa] <= acc_wd;
      end
      if (acc_re) begin
         acc_q_ff <= acc_mem[acc_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (pp_we) begin
         pp_mem[pp_wa] <= pp_wd;
      end
      if (pp_re) begin
         pp_q_ff <= pp_mem[pp_ra];
      end
   end

   always_comb begin
      state_in     = state_ff;
      cur_p_in     = cur_p_ff;
      acc_in       = acc_ff;
      old_in       = old_ff;
      cnt_in       = cnt_ff;
      rnew_in      = rnew_ff;
      pfree_in     = pfree_ff;
      pexh_in      = pexh_ff;
      ncv_in       = ncv_ff;
      accv_in      = accv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      nc_re  = 1'b0;
      nc_ra  = cur_p_ff;
      nc_we  = 1'b0;
      nc_wa  = cur_p_ff;
      nc_wd  = nc_next;
      acc_re = 1'b0;
      acc_ra = acc_ff;
      acc_we = 1'b0;
      acc_wa = acc_ff;
      acc_wd = cur_p_ff;
      pp_re  = 1'b0;
      pp_ra  = cnt_ff;
      pp_we  = 1'b0;
      pp_wa  = cur_p_ff;
      pp_wd  = acc_ff;

      tbl_rd.en   = 1'b0;
      tbl_rd.rank = 1'b0;
      tbl_rd.row  = PW'(cur_p_ff);
      tbl_rd.col  = PW'(nc_cur[IW-1:0]);

      case (state_ff)
         sme_pkg::ST_IDLE: begin
            if (req_fire && (req_data.op == sme_pkg::OP_RUN)) begin
               pfree_in = '1;
               pexh_in  = '0;
               ncv_in   = '0;
               accv_in  = '0;
               state_in = sme_pkg::ST_FIND;
            end
         end
         sme_pkg::ST_FIND: begin
            if (found) begin
               cur_p_in = found_p;
               nc_re    = 1'b1;
               nc_ra    = found_p;
               state_in = sme_pkg::ST_NEXT;
            end else begin
               cnt_in   = '0;
               state_in = sme_pkg::ST_OUT_RD;
            end
         end
         sme_pkg::ST_NEXT: begin
            tbl_rd.en        = 1'b1;
            nc_we            = 1'b1;
            ncv_in[cur_p_ff] = 1'b1;
            if (nc_next == NW'(PEOPLE)) begin
               pexh_in[cur_p_ff] = 1'b1;
            end
            state_in = sme_pkg::ST_PREF;
         end
         sme_pkg::ST_PREF: begin
            if ({1'b0, tbl_q} >= (PW + 1)'(PEOPLE)) begin
               state_in = sme_pkg::ST_FIND;
            end else begin
               acc_in   = tbl_q[IW-1:0];
               acc_re   = 1'b1;
               acc_ra   = tbl_q[IW-1:0];
               state_in = sme_pkg::ST_ACC;
            end
         end
         sme_pkg::ST_ACC: begin
            if (!accv_ff[acc_ff]) begin
               acc_we            = 1'b1;
               accv_in[acc_ff]   = 1'b1;
               pp_we             = 1'b1;
               pfree_in[cur_p_ff] = 1'b0;
               state_in          = sme_pkg::ST_FIND;
            end else begin
               old_in      = acc_q_ff;
               tbl_rd.en   = 1'b1;
               tbl_rd.rank = 1'b1;
               tbl_rd.row  = PW'(acc_ff);
               tbl_rd.col  = PW'(cur_p_ff);
               state_in    = sme_pkg::ST_RANK_NEW;
            end
         end
         sme_pkg::ST_RANK_NEW: begin
            rnew_in     = tbl_q;
            tbl_rd.en   = 1'b1;
            tbl_rd.rank = 1'b1;
            tbl_rd.row  = PW'(acc_ff);
            tbl_rd.col  = PW'(old_ff);
            state_in    = sme_pkg::ST_RANK_OLD;
         end
         sme_pkg::ST_RANK_OLD: begin
            if (rnew_ff < tbl_q) begin
               acc_we             = 1'b1;
               pp_we              = 1'b1;
               pfree_in[old_ff]   = 1'b1;
               pfree_in[cur_p_ff] = 1'b0;
            end
            state_in = sme_pkg::ST_FIND;
         end
         sme_pkg::ST_OUT_RD: begin
            pp_re    = 1'b1;
            state_in = sme_pkg::ST_OUT_WR;
         end
         sme_pkg::ST_OUT_WR: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.proposer         = PW'(cnt_ff);
               rsp_data_in.matched_acceptor = pfree_ff[cnt_ff] ? '0 : PW'(pp_q_ff);
               rsp_data_in.last             = (cnt_ff == IW'(PEOPLE - 1));
               if (cnt_ff == IW'(PEOPLE - 1)) begin
                  state_in = sme_pkg::ST_IDLE;
               end else begin
                  cnt_in   = cnt_ff + IW'(1);
                  state_in = sme_pkg::ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = sme_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/sme_tables.sv
// ----------------------------------------------------------------------------
// sme_tables
// Proposer preference and acceptor rank tables: load port and one read port.
// ----------------------------------------------------------------------------
module sme_tables #(
   parameter int PEOPLE = sme_pkg::DEFAULT_NUM_PEOPLE
) (
   input  logic                         clock,
   input  logic                         load_en,
   input  sme_pkg::req_type             load_req,
   input  sme_pkg::tbl_rd_type          rd,
   output logic [sme_pkg::PERSON_W-1:0] rd_data
);

   localparam int DEPTH = PEOPLE * PEOPLE;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = sme_pkg::PERSON_W + 1;

   logic [sme_pkg::PERSON_W-1:0] pref_mem [DEPTH];
   logic [sme_pkg::PERSON_W-1:0] rank_mem [DEPTH];

   logic [sme_pkg::PERSON_W-1:0] pref_q_ff;
   logic [sme_pkg::PERSON_W-1:0] rank_q_ff;
   logic                         sel_rank_ff;

   logic          person_ok;
   logic          rank_ok;
   logic          partner_ok;
   logic          pref_we;
   logic          rank_we;
   logic [AW-1:0] pref_wa;
   logic [AW-1:0] rank_wa;
   logic [AW-1:0] rd_addr;

   always_comb begin
      person_ok  = {1'b0, load_req.person}   < CW'(PEOPLE);
      rank_ok    = {1'b0, load_req.rank_pos} < CW'(PEOPLE);
      partner_ok = {1'b0, load_req.partner}  < CW'(PEOPLE);
      pref_we    = load_en && (load_req.op == sme_pkg::OP_LOAD_PROP) && person_ok && rank_ok;
      rank_we    = load_en && (load_req.op == sme_pkg::OP_LOAD_ACC) && person_ok && partner_ok;
      pref_wa    = AW'(int'(load_req.person) * PEOPLE + int'(load_req.rank_pos));
      rank_wa    = AW'(int'(load_req.person) * PEOPLE + int'(load_req.partner));
      rd_addr    = AW'(int'(rd.row) * PEOPLE + int'(rd.col));
   end

   always_ff @(posedge clock) begin
      if (pref_we) begin
         pref_mem[pref_wa] <= load_req.partner;
      end
      if (rd.en && !rd.rank) begin
         pref_q_ff <= pref_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rank_we) begin
         rank_mem[rank_wa] <= load_req.rank_pos;
      end
      if (rd.en && rd.rank) begin
         rank_q_ff <= rank_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         sel_rank_ff <= rd.rank;
      end
   end

   assign rd_data = sel_rank_ff ? rank_q_ff : pref_q_ff;

endmodule
